/* rtl/tqs_pkg.sv */
// Package for the task queue scheduler: task status codes, event codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tqs_pkg;

   typedef enum logic [1:0] {
      ST_BLOCKED = 2'd0,
      ST_RUNNING = 2'd1,
      ST_READY   = 2'd2,
      ST_EXITED  = 2'd3
   } task_st_type;

   typedef enum logic [2:0] {
      OP_YIELD   = 3'd0,
      OP_SLEEP   = 3'd1,
      OP_UNBLOCK = 3'd2,
      OP_CREATE  = 3'd3,
      OP_EXIT    = 3'd4,
      OP_KILL    = 3'd5,
      OP_WAIT    = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      SEL_KEEP = 3'd0,
      SEL_CUR  = 3'd1,
      SEL_SLOT = 3'd2,
      SEL_RH   = 3'd3,
      SEL_WH   = 3'd4,
      SEL_SCAN = 3'd5
   } sel_src_type;

   typedef enum logic [1:0] {
      OWN_SRC_READY = 2'd0,
      OWN_SRC_SLEEP = 2'd1,
      OWN_SRC_WAIT  = 2'd2
   } own_src_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SCAN, S_WAIT_BLK, S_BLK_UNL, S_BLK_LNK,
      S_RDY_UNL, S_RDY_LNK, S_KIL_UNL, S_REL_CHK, S_REL_UNL, S_REL_LNK,
      S_SCH_CHK, S_SCH_UNL, S_SCH_LNK, S_SCH_PICK, S_SCH_TAKE, S_RESP
   } state_type;

   typedef struct packed {
      logic        latch;
      sel_src_type sel_src;
      logic        set_st;
      task_st_type st_val;
      logic        unlink;
      logic        link;
      own_src_type own_src;
      logic        set_cur;
      logic        set_wslot;
      logic        create_fill;
      logic        scan_init;
      logic        scan_create;
      logic        scan_step;
      logic        set_err;
      logic        respond;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   rh_nil;
      logic   wh_nil;
      logic   cur_resched;
      logic   scan_hit;
      logic   scan_end;
      logic   found_exited;
      logic   slot_bad;
      logic   image_bad;
      logic   pid_zero;
      logic   kill_cur;
   } status_type;

endpackage

/* rtl/tqs_ctrl.sv */
// Controller for the task queue scheduler: sequences one event as list micro-steps.
// Depends on tqs_pkg.
module tqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tqs_pkg::status_type status,
   output tqs_pkg::cmd_type   cmd
);
   import tqs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               OP_YIELD: state_in = S_SCH_CHK;
               OP_SLEEP: begin
                  cmd.sel_src = SEL_CUR;
                  cmd.set_st  = 1'b1;
                  cmd.st_val  = ST_BLOCKED;
                  state_in    = S_BLK_UNL;
               end
               OP_UNBLOCK: begin
                  if (status.slot_bad) begin
                     cmd.set_err = 1'b1;
                     state_in    = S_RESP;
                  end else begin
                     cmd.sel_src = SEL_SLOT;
                     cmd.set_st  = 1'b1;
                     cmd.st_val  = ST_READY;
                     state_in    = S_RDY_UNL;
                  end
               end
               OP_CREATE: begin
                  if (status.image_bad) begin
                     cmd.set_err = 1'b1;
                     state_in    = S_RESP;
                  end else begin
                     cmd.scan_init   = 1'b1;
                     cmd.scan_create = 1'b1;
                     state_in        = S_SCAN;
                  end
               end
               OP_EXIT: begin
                  cmd.sel_src   = SEL_CUR;
                  cmd.set_st    = 1'b1;
                  cmd.st_val    = ST_EXITED;
                  cmd.set_wslot = 1'b1;
                  state_in      = S_REL_CHK;
               end
               OP_KILL, OP_WAIT: begin
                  if (status.pid_zero) begin
                     cmd.set_err = 1'b1;
                     state_in    = S_RESP;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
                  cmd.set_err = 1'b1;
                  state_in    = S_RESP;
               end
            endcase
         end
         S_SCAN: begin
            if (status.scan_end) begin
               cmd.set_err = 1'b1;
               state_in    = S_RESP;
            end else if (!status.scan_hit) begin
               cmd.scan_step = 1'b1;
            end else if (status.op == OP_CREATE) begin
               cmd.sel_src     = SEL_SCAN;
               cmd.create_fill = 1'b1;
               cmd.set_st      = 1'b1;
               cmd.st_val      = ST_READY;
               state_in        = S_RDY_UNL;
            end else if (status.op == OP_KILL) begin
               if (status.found_exited) begin
                  cmd.set_err = 1'b1;
                  state_in    = S_RESP;
               end else begin
                  cmd.sel_src   = SEL_SCAN;
                  cmd.set_st    = 1'b1;
                  cmd.st_val    = ST_EXITED;
                  cmd.set_wslot = 1'b1;
                  state_in      = S_KIL_UNL;
               end
            end else begin
               // wait on an exited task succeeds with no change
               if (status.found_exited) begin
                  state_in = S_RESP;
               end else begin
                  cmd.sel_src   = SEL_SCAN;
                  cmd.set_wslot = 1'b1;
                  state_in      = S_WAIT_BLK;
               end
            end
         end
         S_WAIT_BLK: begin
            cmd.sel_src = SEL_CUR;
            cmd.set_st  = 1'b1;
            cmd.st_val  = ST_BLOCKED;
            state_in    = S_BLK_UNL;
         end
         S_BLK_UNL: begin
            cmd.unlink = 1'b1;
            state_in   = S_BLK_LNK;
         end
         S_BLK_LNK: begin
            cmd.link    = 1'b1;
            cmd.own_src = (status.op == OP_SLEEP) ? OWN_SRC_SLEEP : OWN_SRC_WAIT;
            state_in    = S_SCH_CHK;
         end
         S_RDY_UNL: begin
            cmd.unlink = 1'b1;
            state_in   = S_RDY_LNK;
         end
         S_RDY_LNK: begin
            cmd.link    = 1'b1;
            cmd.own_src = OWN_SRC_READY;
            state_in    = S_RESP;
         end
         S_KIL_UNL: begin
            cmd.unlink = 1'b1;
            state_in   = S_REL_CHK;
         end
         S_REL_CHK: begin
            if (status.wh_nil) begin
               if (status.op == OP_KILL && !status.kill_cur) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCH_CHK;
               end
            end else begin
               cmd.sel_src = SEL_WH;
               cmd.set_st  = 1'b1;
               cmd.st_val  = ST_READY;
               state_in    = S_REL_UNL;
            end
         end
         S_REL_UNL: begin
            cmd.unlink = 1'b1;
            state_in   = S_REL_LNK;
         end
         S_REL_LNK: begin
            cmd.link    = 1'b1;
            cmd.own_src = OWN_SRC_READY;
            state_in    = S_REL_CHK;
         end
         S_SCH_CHK: begin
            if (status.rh_nil) begin
               state_in = S_RESP;
            end else if (status.cur_resched) begin
               cmd.sel_src = SEL_CUR;
               cmd.set_st  = 1'b1;
               cmd.st_val  = ST_READY;
               state_in    = S_SCH_UNL;
            end else begin
               state_in = S_SCH_PICK;
            end
         end
         S_SCH_UNL: begin
            cmd.unlink = 1'b1;
            state_in   = S_SCH_LNK;
         end
         S_SCH_LNK: begin
            cmd.link    = 1'b1;
            cmd.own_src = OWN_SRC_READY;
            state_in    = S_SCH_PICK;
         end
         S_SCH_PICK: begin
            cmd.sel_src = SEL_RH;
            cmd.set_st  = 1'b1;
            cmd.st_val  = ST_RUNNING;
            cmd.set_cur = 1'b1;
            state_in    = S_SCH_TAKE;
         end
         S_SCH_TAKE: begin
            cmd.unlink = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/tqs_datapath.sv */
// Datapath for the task queue scheduler: task table, list links, queue ends,
// slot scan and result registers. Depends on tqs_pkg.
module tqs_datapath #(
   parameter int TASK_SLOTS  = 16,
   parameter int IMAGE_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  tqs_pkg::cmd_type    cmd,
   output tqs_pkg::status_type status,
   input  logic [2:0]         req_operation,
   input  logic [3:0]         req_task_slot,
   input  logic [15:0]        req_target_pid,
   input  logic [7:0]         req_image_id,
   output logic               rsp_strobe,
   output logic               rsp_status_code,
   output logic [15:0]        rsp_new_pid,
   output logic [3:0]         rsp_running_slot,
   output logic [15:0]        rsp_running_pid,
   output logic               rsp_switched
);
   import tqs_pkg::*;

   localparam int IW = (TASK_SLOTS > 2) ? $clog2(TASK_SLOTS) : 1;
   localparam int SW = $clog2(TASK_SLOTS + 1);
   localparam int OW = $clog2(TASK_SLOTS + 3);
   localparam int XW = (IW > 4) ? IW : 4;
   localparam logic [SW-1:0] NIL       = SW'(TASK_SLOTS);
   localparam logic [OW-1:0] OWN_READY = OW'(TASK_SLOTS);
   localparam logic [OW-1:0] OWN_SLEEP = OW'(TASK_SLOTS + 1);
   localparam logic [OW-1:0] OWN_NONE  = OW'(TASK_SLOTS + 2);
   localparam logic [OW-1:0] OWN_SLOTS = OW'(TASK_SLOTS);

   logic [15:0]   pid_ff  [TASK_SLOTS];
   task_st_type   stat_ff [TASK_SLOTS];
   logic [SW-1:0] next_ff [TASK_SLOTS];
   logic [SW-1:0] prev_ff [TASK_SLOTS];
   logic [OW-1:0] own_ff  [TASK_SLOTS];
   logic [SW-1:0] wh_ff   [TASK_SLOTS];
   logic [SW-1:0] wt_ff   [TASK_SLOTS];
   logic [SW-1:0] rh_ff, rt_ff, sh_ff, stl_ff;
   logic [IW-1:0] cur_ff, before_ff, sel_ff, sel_in, wslot_ff;
   logic [15:0]   npid_ff, made_ff;
   logic [SW-1:0] scan_ff;
   logic          scan_create_ff, err_ff;
   logic [2:0]    op_ff;
   logic [3:0]    slot_ff;
   logic [15:0]   tpid_ff;
   logic [7:0]    image_ff;

   // unlink terms
   logic [OW-1:0] u_own;
   logic [SW-1:0] u_p, u_n;
   logic          u_on;
   // link terms
   logic [OW-1:0] l_own;
   logic [SW-1:0] l_tail;
   // queue end writes
   logic          hd_wr, tl_wr;
   logic [OW-1:0] hd_own, tl_own;
   logic [SW-1:0] hd_val, tl_val;
   logic [IW-1:0] slot_idx, scan_idx;
   logic [XW-1:0] slot_x, cur_x;

   assign slot_x   = XW'(slot_ff);
   assign slot_idx = slot_x[IW-1:0];
   assign scan_idx = scan_ff[IW-1:0];
   assign cur_x    = XW'(cur_ff);

   always_comb begin
      case (cmd.sel_src)
         SEL_CUR:  sel_in = cur_ff;
         SEL_SLOT: sel_in = slot_idx;
         SEL_RH:   sel_in = rh_ff[IW-1:0];
         SEL_WH:   sel_in = wh_ff[wslot_ff][IW-1:0];
         SEL_SCAN: sel_in = scan_idx;
         default:  sel_in = sel_ff;
      endcase
   end

   assign u_own = own_ff[sel_ff];
   assign u_p   = prev_ff[sel_ff];
   assign u_n   = next_ff[sel_ff];
   assign u_on  = (u_own < OWN_NONE);

   always_comb begin
      case (cmd.own_src)
         OWN_SRC_READY: l_own = OWN_READY;
         OWN_SRC_SLEEP: l_own = OWN_SLEEP;
         default:       l_own = OW'(wslot_ff);
      endcase
      if (l_own < OWN_SLOTS) begin
         l_tail = wt_ff[l_own[IW-1:0]];
      end else if (l_own == OWN_READY) begin
         l_tail = rt_ff;
      end else begin
         l_tail = stl_ff;
      end
   end

   always_comb begin
      hd_wr  = 1'b0;
      tl_wr  = 1'b0;
      hd_own = u_own;
      tl_own = u_own;
      hd_val = u_n;
      tl_val = u_p;
      if (cmd.unlink && u_on) begin
         hd_wr = (u_p >= NIL);
         tl_wr = (u_n >= NIL);
      end else if (cmd.link) begin
         hd_own = l_own;
         tl_own = l_own;
         hd_val = SW'(sel_ff);
         tl_val = SW'(sel_ff);
         hd_wr  = (l_tail >= NIL);
         tl_wr  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            pid_ff[i]  <= '0;
            stat_ff[i] <= ST_BLOCKED;
            own_ff[i]  <= OWN_NONE;
            wh_ff[i]   <= NIL;
            wt_ff[i]   <= NIL;
         end
         rh_ff      <= NIL;
         rt_ff      <= NIL;
         sh_ff      <= NIL;
         stl_ff     <= NIL;
         cur_ff     <= '0;
         npid_ff    <= 16'd1;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.respond;
         if (cmd.latch) begin
            op_ff     <= req_operation;
            slot_ff   <= req_task_slot;
            tpid_ff   <= req_target_pid;
            image_ff  <= req_image_id;
            before_ff <= cur_ff;
            err_ff    <= 1'b0;
            made_ff   <= '0;
         end
         sel_ff <= sel_in;
         if (cmd.set_st) stat_ff[sel_in] <= cmd.st_val;
         if (cmd.set_cur) cur_ff <= sel_in;
         if (cmd.set_wslot) wslot_ff <= sel_in;
         if (cmd.set_err) err_ff <= 1'b1;
         if (cmd.create_fill) begin
            pid_ff[sel_in] <= npid_ff;
            made_ff        <= npid_ff;
            npid_ff        <= (npid_ff == 16'hFFFF) ? 16'd1 : npid_ff + 16'd1;
         end
         if (cmd.scan_init) begin
            scan_ff        <= cmd.scan_create ? SW'(1) : '0;
            scan_create_ff <= cmd.scan_create;
         end else if (cmd.scan_step) begin
            scan_ff <= scan_ff + SW'(1);
         end
         if (cmd.unlink && u_on) begin
            if (u_p < NIL) next_ff[u_p[IW-1:0]] <= u_n;
            if (u_n < NIL) prev_ff[u_n[IW-1:0]] <= u_p;
            own_ff[sel_ff] <= OWN_NONE;
         end
         if (cmd.link) begin
            next_ff[sel_ff] <= NIL;
            prev_ff[sel_ff] <= l_tail;
            if (l_tail < NIL) next_ff[l_tail[IW-1:0]] <= SW'(sel_ff);
            own_ff[sel_ff] <= l_own;
         end
         if (hd_wr) begin
            if (hd_own < OWN_SLOTS) wh_ff[hd_own[IW-1:0]] <= hd_val;
            else if (hd_own == OWN_READY) rh_ff <= hd_val;
            else sh_ff <= hd_val;
         end
         if (tl_wr) begin
            if (tl_own < OWN_SLOTS) wt_ff[tl_own[IW-1:0]] <= tl_val;
            else if (tl_own == OWN_READY) rt_ff <= tl_val;
            else stl_ff <= tl_val;
         end
      end
   end

   // result beat registers
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_code  <= err_ff;
         rsp_new_pid      <= made_ff;
         rsp_running_slot <= cur_x[3:0];
         rsp_running_pid  <= pid_ff[cur_ff];
         rsp_switched     <= (cur_ff != before_ff);
      end
   end

   always_comb begin
      status.op           = op_type'(op_ff);
      status.rh_nil       = (rh_ff >= NIL);
      status.wh_nil       = (wh_ff[wslot_ff] >= NIL);
      status.cur_resched  = (cur_ff != '0) && (stat_ff[cur_ff] == ST_RUNNING);
      status.scan_end     = (scan_ff >= NIL);
      status.scan_hit     = scan_create_ff ?
                            ((pid_ff[scan_idx] == '0) || (stat_ff[scan_idx] == ST_EXITED)) :
                            (pid_ff[scan_idx] == tpid_ff);
      status.found_exited = (stat_ff[scan_idx] == ST_EXITED);
      status.slot_bad     = (32'(slot_ff) >= TASK_SLOTS) ||
                            (own_ff[slot_idx] == OWN_READY) ||
                            (own_ff[slot_idx] >= OWN_NONE);
      status.image_bad    = (32'(image_ff) >= IMAGE_COUNT);
      status.pid_zero     = (tpid_ff == '0);
      status.kill_cur     = (wslot_ff == cur_ff);
   end

endmodule

/* rtl/task_queue_scheduler.sv */
// Top level of the task queue scheduler: controller plus datapath.
// Depends on tqs_pkg, tqs_ctrl and tqs_datapath.
//
// Usage: drive req_* and raise start; the event is taken at the clock edge
// where start is high and busy is low. busy stays high while the event works
// through the task lists. The result is one beat: rsp_strobe is high for
// exactly one cycle with rsp_* valid; the receiver cannot hold it off, and
// busy drops in that same cycle, so the next event may be taken then.
// A move between lists is an unlink state followed by a link state. Create,
// kill and wait scan the task slots in order before any list edit, and exit
// and kill then release each waiter through a check, an unlink and a link
// state. The slot scan and the waiter release make the longest events.
// Reset (synchronous, active high) frees all slots, empties all queues, makes
// slot 0 the running boot task and sets the next pid to one.
module task_queue_scheduler #(
   parameter int TASK_SLOTS  = 16,
   parameter int IMAGE_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_task_slot,
   input  logic [15:0] req_target_pid,
   input  logic [7:0]  req_image_id,
   output logic        rsp_strobe,
   output logic        rsp_status_code,
   output logic [15:0] rsp_new_pid,
   output logic [3:0]  rsp_running_slot,
   output logic [15:0] rsp_running_pid,
   output logic        rsp_switched
);
   import tqs_pkg::*;

   cmd_type    cmd;
   status_type status;

   tqs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tqs_datapath #(
      .TASK_SLOTS  (TASK_SLOTS),
      .IMAGE_COUNT (IMAGE_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_task_slot    (req_task_slot),
      .req_target_pid   (req_target_pid),
      .req_image_id     (req_image_id),
      .rsp_strobe       (rsp_strobe),
      .rsp_status_code  (rsp_status_code),
      .rsp_new_pid      (rsp_new_pid),
      .rsp_running_slot (rsp_running_slot),
      .rsp_running_pid  (rsp_running_pid),
      .rsp_switched     (rsp_switched)
   );

endmodule

/* rtl/tqs_checker.sv */
// Port-level checks for the task queue scheduler, bound to the top level.
// Depends on task_queue_scheduler.
module tqs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted event did not raise busy");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result beat while busy");
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result beat repeated");
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe) else $error("result beat too early");
endmodule

bind task_queue_scheduler tqs_checker u_tqs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for task_queue_scheduler: a directed event table, then random events.
// Each result is checked against the row's typed-in expectation where the row has one, else against
// an in-bench model of the task table and its queues. Depends on tqs_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tqs_pkg::*;

   localparam int SLOTS     = 16;
   localparam int IMAGES    = 16;
   localparam int NIL       = SLOTS;     // end of a list
   localparam int Q_READY   = SLOTS;     // owner code: ready queue
   localparam int Q_SLEEP   = SLOTS + 1; // owner code: sleep queue
   localparam int Q_NONE    = SLOTS + 2; // owner code: on no list
   localparam int N_RANDOM  = 530;
   localparam int CYCLE_CAP = 600000;
   localparam logic [2:0] OP_BAD = 3'd7; // unused operation code

   typedef struct {
      logic        err;
      logic [15:0] newp;
      logic [3:0]  rslot;
      logic [15:0] rpid;
      logic        sw;
   } sched_result_type;

   typedef struct {
      logic [2:0]       op;
      logic [3:0]       slot;
      logic [15:0]      pid;
      logic [7:0]       img;
      bit               known;  // expected result typed in below
      sched_result_type res;
   } event_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation  = '0;
   logic [3:0]  req_task_slot  = '0;
   logic [15:0] req_target_pid = '0;
   logic [7:0]  req_image_id   = '0;
   logic        rsp_strobe, rsp_status_code, rsp_switched;
   logic [15:0] rsp_new_pid, rsp_running_pid;
   logic [3:0]  rsp_running_slot;

   task_queue_scheduler #(.TASK_SLOTS(SLOTS), .IMAGE_COUNT(IMAGES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_task_slot(req_task_slot),
      .req_target_pid(req_target_pid), .req_image_id(req_image_id),
      .rsp_strobe(rsp_strobe), .rsp_status_code(rsp_status_code),
      .rsp_new_pid(rsp_new_pid), .rsp_running_slot(rsp_running_slot),
      .rsp_running_pid(rsp_running_pid), .rsp_switched(rsp_switched)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- scheduler model ----------------
   logic [15:0] t_pid[SLOTS];
   task_st_type t_st[SLOTS];
   int          lk_next[SLOTS], lk_prev[SLOTS], t_owner[SLOTS];
   int          w_head[SLOTS], w_tail[SLOTS];
   int          rq_head, rq_tail, sq_head, sq_tail, cur_slot;
   logic [15:0] pid_next;

   sched_result_type pending_results[$];
   int          err_count = 0;
   int          result_count = 0;
   int          op_count[8];
   int          cycles = 0;

   function automatic int head_of(int own);
      if (own < SLOTS) return w_head[own];
      return (own == Q_READY) ? rq_head : sq_head;
   endfunction

   function automatic int tail_of(int own);
      if (own < SLOTS) return w_tail[own];
      return (own == Q_READY) ? rq_tail : sq_tail;
   endfunction

   function automatic void put_head(int own, int v);
      if (own < SLOTS) w_head[own] = v;
      else if (own == Q_READY) rq_head = v;
      else sq_head = v;
   endfunction

   function automatic void put_tail(int own, int v);
      if (own < SLOTS) w_tail[own] = v;
      else if (own == Q_READY) rq_tail = v;
      else sq_tail = v;
   endfunction

   function automatic void list_remove(int s);
      int p, n, own;
      if (t_owner[s] >= Q_NONE) return;
      own = t_owner[s];
      p = lk_prev[s];
      n = lk_next[s];
      if (p < SLOTS) lk_next[p] = n; else put_head(own, n);
      if (n < SLOTS) lk_prev[n] = p; else put_tail(own, p);
      t_owner[s] = Q_NONE;
   endfunction

   function automatic void list_push(int s, int own);
      int t;
      list_remove(s);
      t = tail_of(own);
      lk_next[s] = NIL;
      lk_prev[s] = t;
      if (t < SLOTS) lk_next[t] = s; else put_head(own, s);
      put_tail(own, s);
      t_owner[s] = own;
   endfunction

   // round robin: requeue a running non-boot task, run the ready head
   function automatic void run_next();
      int nx;
      if (rq_head >= SLOTS) return;
      if (cur_slot != 0 && t_st[cur_slot] == ST_RUNNING) begin
         t_st[cur_slot] = ST_READY;
         list_push(cur_slot, Q_READY);
      end
      nx = rq_head;
      list_remove(nx);
      t_st[nx] = ST_RUNNING;
      cur_slot = nx;
   endfunction

   function automatic void wake_waiters(int w);
      int p;
      while (w_head[w] < SLOTS) begin
         p = w_head[w];
         t_st[p] = ST_READY;
         list_push(p, Q_READY);
      end
   endfunction

   function automatic int slot_of_pid(logic [15:0] pid);
      if (pid == 0) return NIL;
      for (int i = 0; i < SLOTS; i++)
         if (t_pid[i] == pid) return i;
      return NIL;
   endfunction

   function automatic void park_current(int own);
      t_st[cur_slot] = ST_BLOCKED;
      list_push(cur_slot, own);
      run_next();
   endfunction

   function automatic void sched_reset();
      for (int i = 0; i < SLOTS; i++) begin
         t_pid[i] = '0;
         t_st[i] = ST_BLOCKED;
         lk_next[i] = NIL;
         lk_prev[i] = NIL;
         t_owner[i] = Q_NONE;
         w_head[i] = NIL;
         w_tail[i] = NIL;
      end
      rq_head = NIL; rq_tail = NIL; sq_head = NIL; sq_tail = NIL;
      cur_slot = 0;
      pid_next = 16'd1;
   endfunction

   function automatic sched_result_type sched_event(logic [2:0] op, logic [3:0] slot,
                                                    logic [15:0] pid, logic [7:0] img);
      sched_result_type r;
      int was, s;
      was = cur_slot;
      r.err = 1'b0;
      r.newp = '0;
      case (op)
         OP_YIELD: run_next();
         OP_SLEEP: park_current(Q_SLEEP);
         OP_UNBLOCK: begin
            if (t_owner[slot] == Q_READY || t_owner[slot] >= Q_NONE) r.err = 1'b1;
            else begin
               t_st[slot] = ST_READY;
               list_push(slot, Q_READY);
            end
         end
         OP_CREATE: begin
            s = NIL;
            if (img < IMAGES)
               for (int i = 1; i < SLOTS; i++)
                  if (s == NIL && (t_pid[i] == 0 || t_st[i] == ST_EXITED)) s = i;
            if (s == NIL) r.err = 1'b1;
            else begin
               t_pid[s] = pid_next;
               r.newp = pid_next;
               pid_next = pid_next + 16'd1;
               if (pid_next == 0) pid_next = 16'd1;
               t_st[s] = ST_READY;
               list_push(s, Q_READY);
            end
         end
         OP_EXIT: begin
            t_st[cur_slot] = ST_EXITED;
            wake_waiters(cur_slot);
            run_next();
         end
         OP_KILL: begin
            s = slot_of_pid(pid);
            if (s == NIL || t_st[s] == ST_EXITED) r.err = 1'b1;
            else begin
               t_st[s] = ST_EXITED;
               list_remove(s);
               wake_waiters(s);
               if (s == cur_slot) run_next();
            end
         end
         OP_WAIT: begin
            s = slot_of_pid(pid);
            if (s == NIL) r.err = 1'b1;
            else if (t_st[s] != ST_EXITED) park_current(s);
         end
         default: r.err = 1'b1;
      endcase
      r.rslot = cur_slot[3:0];
      r.rpid = t_pid[cur_slot];
      r.sw = (cur_slot != was);
      return r;
   endfunction

   // ---------------- driving ----------------
   // Presents one event and returns at the edge that takes it; start is left high.
   task automatic send_event(event_row_type row);
      sched_result_type r;
      req_operation  <= row.op;
      req_task_slot  <= row.slot;
      req_target_pid <= row.pid;
      req_image_id   <= row.img;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      r = sched_event(row.op, row.slot, row.pid, row.img);
      pending_results.push_back(row.known ? row.res : r);
      op_count[row.op]++;
   endtask

   task automatic idle_gap(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // random event, biased toward slots and pids the block actually holds
   function automatic event_row_type random_event();
      event_row_type e;
      int r, cand[$];
      r = $urandom_range(0, 99);
      e.op = (r < 20) ? OP_YIELD : (r < 32) ? OP_SLEEP : (r < 47) ? OP_UNBLOCK :
             (r < 65) ? OP_CREATE : (r < 74) ? OP_EXIT : (r < 85) ? OP_KILL :
             (r < 97) ? OP_WAIT : OP_BAD;
      for (int i = 0; i < SLOTS; i++)
         if (t_owner[i] != Q_READY && t_owner[i] != Q_NONE) cand.push_back(i);
      if (cand.size() > 0 && $urandom_range(0, 99) < 80)
         e.slot = 4'(cand[$urandom_range(0, cand.size() - 1)]);
      else
         e.slot = 4'($urandom_range(0, 15));
      e.pid = ($urandom_range(0, 99) < 85) ? t_pid[$urandom_range(0, SLOTS - 1)]
                                           : 16'($urandom());
      e.img = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, IMAGES - 1))
                                           : 8'($urandom());
      e.known = 1'b0;
      e.res = '{1'b0, 16'd0, 4'd0, 16'd0, 1'b0};
      return e;
   endfunction

   // ---------------- checking ----------------
   always @(posedge clock) begin
      sched_result_type x;
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         result_count <= result_count + 1;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            err_count++;
         end else begin
            x = pending_results.pop_front();
            if (rsp_status_code !== x.err) begin
               $error("status_code exp %0d got %0d", x.err, rsp_status_code);
               err_count++;
            end
            if (rsp_new_pid !== x.newp) begin
               $error("new_pid exp %0d got %0d", x.newp, rsp_new_pid);
               err_count++;
            end
            if (rsp_running_slot !== x.rslot) begin
               $error("running_slot exp %0d got %0d", x.rslot, rsp_running_slot);
               err_count++;
            end
            if (rsp_running_pid !== x.rpid) begin
               $error("running_pid exp %0d got %0d", x.rpid, rsp_running_pid);
               err_count++;
            end
            if (rsp_switched !== x.sw) begin
               $error("switched exp %0d got %0d", x.sw, rsp_switched);
               err_count++;
            end
         end
      end
   end

   // run-away guard
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   event_row_type directed[$];

   function automatic event_row_type row(logic [2:0] op, logic [3:0] slot, logic [15:0] pid,
                                         logic [7:0] img, bit known, logic err,
                                         logic [15:0] newp, logic [3:0] rs,
                                         logic [15:0] rp, logic sw);
      event_row_type e;
      e.op = op; e.slot = slot; e.pid = pid; e.img = img; e.known = known;
      e.res = '{err, newp, rs, rp, sw};
      return e;
   endfunction

   initial begin
      sched_reset();
      // right after reset, then error codes and extremes
      directed.push_back(row(OP_YIELD,   4'd0,  16'd0,      8'd0,   1, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_BAD,     4'd0,  16'd0,      8'd0,   1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_UNBLOCK, 4'd5,  16'd0,      8'd0,   1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_UNBLOCK, 4'd15, 16'd0,      8'd0,   1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_KILL,    4'd0,  16'd0,      8'd0,   1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_WAIT,    4'd0,  16'd0,      8'd0,   1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_KILL,    4'd0,  16'hFFFF,   8'd0,   1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_CREATE,  4'd0,  16'd0,      8'd16,  1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_CREATE,  4'd0,  16'd0,      8'd255, 1, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_CREATE,  4'd0,  16'd0,      8'd0,   1, 0, 1, 0, 0, 0));
      directed.push_back(row(OP_CREATE,  4'd0,  16'd0,      8'd15,  1, 0, 2, 0, 0, 0));
      // boot task is not requeued: slot 1 runs
      directed.push_back(row(OP_YIELD,   4'd0,  16'd0,      8'd0,   1, 0, 0, 1, 1, 1));
      directed.push_back(row(OP_WAIT,    4'd0,  16'd2,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_CREATE,  4'd0,  16'd0,      8'd3,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_SLEEP,   4'd0,  16'd0,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_UNBLOCK, 4'd1,  16'd0,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_UNBLOCK, 4'd2,  16'd0,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_EXIT,    4'd0,  16'd0,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_KILL,    4'd0,  16'd3,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_KILL,    4'd0,  16'd3,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_WAIT,    4'd0,  16'd3,      8'd0,   0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_YIELD,   4'd0,  16'd0,      8'd0,   0, 0, 0, 0, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_event(directed[i]);
         if ($urandom_range(0, 99) < 27) idle_gap($urandom_range(1, 4));
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         send_event(random_event());
         if (n == 400) begin
            // hold off until the block has drained
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end else if ((n < 200 || n > 320) && $urandom_range(0, 99) < 27) begin
            idle_gap($urandom_range(1, 6));
         end
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("events: yield %0d sleep %0d unblock %0d create %0d exit %0d kill %0d wait %0d bad %0d",
               op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
               op_count[5], op_count[6], op_count[7]);
      $display("%0d result beats checked over %0d cycles", result_count, cycles);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
rtl/tqs_pkg.sv
rtl/tqs_ctrl.sv
rtl/tqs_datapath.sv
rtl/task_queue_scheduler.sv
rtl/tqs_checker.sv
tb/sv/tb_top.sv
